### src/otp_pkg.sv
// Shared types and constants for the one-shot timer pool.
// Holds the request and response codes, the field widths, the state type and the converter response type.
// No dependencies.
package otp_pkg;

  localparam int REQ_W       = 3;
  localparam int SLOT_ID_W   = 8;
  localparam int MS_W        = 32;
  localparam int KIND_W      = 3;
  localparam int RESP_SLOT_W = 6;
  localparam int TICKS_W     = 26;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 16;

  localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RESTART = 3'd5;

  localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CREATED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FAIL    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_END,
    ST_DIV,
    ST_FIND,
    ST_START_RD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               done;
    logic [TICKS_W-1:0] ticks;
  } div_rsp_t;

endpackage

### src/otp_div.sv
// Converter from milliseconds to ticks, rounding up and saturating.
// Multiplies by a fixed reciprocal of TICK_MS in two chunked steps. Depends on otp_pkg.
module otp_div
  import otp_pkg::*;
#(
  parameter int TICK_MS = 100
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [MS_W-1:0] ms,
  output div_rsp_t        rsp
);

  // The rounded-up dividend stays below 2^(MS_W+1); it is split into two equal chunks.
  localparam int NUM_W   = MS_W + 2;
  localparam int CHUNK_W = NUM_W / 2;
  localparam int RCP_W   = MS_W + 3;
  localparam int PART_W  = CHUNK_W + RCP_W;
  localparam int ACC_W   = 72;
  localparam int SHIFT   = MS_W + 1 + $clog2(TICK_MS);
  // Reciprocal rounded up; the quotient is exact for every dividend below 2^(MS_W+1).
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  logic              busy;
  logic              done;
  logic              step;
  logic [NUM_W-1:0]  num;
  logic [ACC_W-1:0]  acc;
  logic [PART_W-1:0] part;

  assign part = num[NUM_W-1 -: CHUNK_W] * RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 1'b0;
      end else if (busy) begin
        step <= 1'b1;
        if (step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The high chunk's product is shifted up while the low chunk's product is added.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= NUM_W'(ms) + NUM_W'(TICK_MS - 1);
      acc <= '0;
    end else if (busy) begin
      num <= num << CHUNK_W;
      acc <= (acc << CHUNK_W) + ACC_W'(part);
    end
  end

  assign rsp.done  = done;
  assign rsp.ticks = (|acc[ACC_W-1:SHIFT+TICKS_W]) ? TICKS_MAX : acc[SHIFT +: TICKS_W];

endmodule

### src/one_shot_timer_pool_core.sv
// One-shot timer pool: tick scan over a countdown memory, and slot commands.
// A tick visits every slot in turn. Create converts the interval and then visits slots in
// turn until it finds a free one; restart converts the interval; start reads the stored
// reload value first; delete, stop and unknown requests go straight to the response.
// An output word that waits for the receiver holds the block. One item is in work at a time.
// Reset clears the slot flags and control at once; the tick memories need no clearing pass.
module one_shot_timer_pool_core
  import otp_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int TICK_MS   = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // req_type[2:0], slot_id[10:3], interval_ms[42:11]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // resp_kind[2:0], resp_slot[8:3]
  output logic                 m_tlast
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t state, state_next;

  logic [REQ_W-1:0]     in_req;
  logic [SLOT_ID_W-1:0] in_id;
  logic [MS_W-1:0]      in_ms;
  logic                 accept;

  logic [REQ_W-1:0]     req;
  logic [SLOT_ID_W-1:0] id;
  logic [IDX_W-1:0]     id_idx;
  logic                 id_ok;
  logic [IDX_W-1:0]     idx;
  logic [TICKS_W-1:0]   ticks;

  logic [NUM_SLOTS-1:0] used;
  logic [NUM_SLOTS-1:0] running;

  logic                 pend_valid;
  logic [IDX_W-1:0]     pend_slot;

  logic                 out_valid;
  logic [KIND_W-1:0]    out_kind;
  logic [RESP_SLOT_W-1:0] out_slot;
  logic                 out_last;
  logic                 load_ok;

  logic                 div_start;
  div_rsp_t             div_rsp;

  logic [TICKS_W-1:0]   reload_mem [NUM_SLOTS];
  logic [TICKS_W-1:0]   remain_mem [NUM_SLOTS];
  logic [TICKS_W-1:0]   reload_rdata;
  logic [TICKS_W-1:0]   remain_rdata;
  logic [IDX_W-1:0]     rd_addr;

  logic                 reload_we;
  logic [IDX_W-1:0]     reload_waddr;
  logic [TICKS_W-1:0]   reload_wdata;
  logic                 remain_we;
  logic [IDX_W-1:0]     remain_waddr;
  logic [TICKS_W-1:0]   remain_wdata;

  logic                 use_set, use_clr, run_set, run_clr;
  logic [IDX_W-1:0]     flag_idx;

  logic                 push;
  logic [KIND_W-1:0]    push_kind;
  logic [RESP_SLOT_W-1:0] push_slot;
  logic                 push_last;

  logic                 slot_active;
  logic                 expire;
  logic                 stall;

  assign in_req = s_tdata[REQ_W-1:0];
  assign in_id  = s_tdata[REQ_W +: SLOT_ID_W];
  assign in_ms  = s_tdata[REQ_W + SLOT_ID_W +: MS_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_ok  = !out_valid || m_tready;

  assign id_idx = id[IDX_W-1:0];
  assign id_ok  = (id < SLOT_ID_W'(NUM_SLOTS)) && used[id_idx];

  assign slot_active = used[idx] && running[idx];
  assign expire      = slot_active && (remain_rdata == '0);
  // A second expiry cannot move into the pending slot until the first one leaves.
  assign stall       = expire && pend_valid && !load_ok;

  assign div_start = accept && (in_req == REQ_CREATE || in_req == REQ_RESTART);

  otp_div #(
    .TICK_MS(TICK_MS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .ms   (in_ms),
    .rsp  (div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (in_req) inside
            REQ_TICK:                state_next = ST_PRIME;
            REQ_CREATE, REQ_RESTART: state_next = ST_DIV;
            REQ_START:               state_next = ST_START_RD;
            default:                 state_next = ST_RESP;
          endcase
        end
      end
      ST_PRIME:    state_next = ST_SCAN;
      ST_SCAN: begin
        if (!stall && idx == LAST_IDX) state_next = ST_END;
      end
      ST_END: begin
        if (load_ok) state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = (req == REQ_CREATE) ? ST_FIND : ST_RESP;
      end
      ST_FIND: begin
        if (!used[idx] || idx == LAST_IDX) state_next = ST_RESP;
      end
      ST_START_RD: state_next = ST_RESP;
      ST_RESP: begin
        if (load_ok) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr      = id_idx;
    reload_we    = 1'b0;
    reload_waddr = id_idx;
    reload_wdata = ticks;
    remain_we    = 1'b0;
    remain_waddr = id_idx;
    remain_wdata = ticks;
    use_set      = 1'b0;
    use_clr      = 1'b0;
    run_set      = 1'b0;
    run_clr      = 1'b0;
    flag_idx     = id_idx;
    push         = 1'b0;
    push_kind    = KIND_FAIL;
    push_slot    = '0;
    push_last    = 1'b1;
    unique case (state)
      ST_PRIME: rd_addr = '0;
      ST_SCAN: begin
        rd_addr  = stall ? idx : idx + 1'b1;
        flag_idx = idx;
        if (!stall) begin
          if (slot_active && !expire) begin
            remain_we    = 1'b1;
            remain_waddr = idx;
            remain_wdata = remain_rdata - 1'b1;
          end
          if (expire) begin
            run_clr = 1'b1;
            if (pend_valid) begin
              push      = 1'b1;
              push_kind = KIND_EXPIRED;
              push_slot = RESP_SLOT_W'(pend_slot);
              push_last = 1'b0;
            end
          end
        end
      end
      ST_END: begin
        push      = load_ok;
        push_kind = pend_valid ? KIND_EXPIRED : KIND_IDLE;
        push_slot = pend_valid ? RESP_SLOT_W'(pend_slot) : '0;
      end
      ST_RESP: begin
        push = load_ok;
        case (req) inside
          REQ_CREATE: begin
            flag_idx = idx;
            if (!used[idx]) begin
              push_kind    = KIND_CREATED;
              push_slot    = RESP_SLOT_W'(idx);
              use_set      = load_ok;
              run_clr      = load_ok;
              reload_we    = load_ok;
              reload_waddr = idx;
            end
          end
          REQ_DELETE, REQ_START, REQ_STOP, REQ_RESTART: begin
            push_slot = id[RESP_SLOT_W-1:0];
            if (id_ok) begin
              push_kind = KIND_DONE;
              if (req == REQ_DELETE) begin
                use_clr = load_ok;
                run_clr = load_ok;
              end else if (req == REQ_STOP) begin
                run_clr = load_ok;
              end else if (req == REQ_START) begin
                run_set      = load_ok;
                remain_we    = load_ok;
                remain_wdata = reload_rdata;
              end else begin
                run_set   = load_ok;
                reload_we = load_ok;
                remain_we = load_ok;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      running    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (use_set) used[flag_idx] <= 1'b1;
      if (use_clr) used[flag_idx] <= 1'b0;
      if (run_set) running[flag_idx] <= 1'b1;
      if (run_clr) running[flag_idx] <= 1'b0;

      if (accept) begin
        idx <= '0;
      end else if (state == ST_SCAN && !stall && idx != LAST_IDX) begin
        idx <= idx + 1'b1;
      end else if (state == ST_FIND && used[idx] && idx != LAST_IDX) begin
        idx <= idx + 1'b1;
      end

      if (state == ST_SCAN && !stall && expire) begin
        pend_valid <= 1'b1;
      end else if (state == ST_END && load_ok) begin
        pend_valid <= 1'b0;
      end

      if (push) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_req;
      id  <= in_id;
    end
    if (div_rsp.done) ticks <= div_rsp.ticks;
    if (state == ST_SCAN && !stall && expire) pend_slot <= idx;
    if (push) begin
      out_kind <= push_kind;
      out_slot <= push_slot;
      out_last <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (reload_we) reload_mem[reload_waddr] <= reload_wdata;
    if (remain_we) remain_mem[remain_waddr] <= remain_wdata;
    reload_rdata <= reload_mem[rd_addr];
    remain_rdata <= remain_mem[rd_addr];
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W - KIND_W - RESP_SLOT_W){1'b0}}, out_slot, out_kind};
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while a word is waiting");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("tick conversion finished outside its wait state");

  a_pend_in_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_SCAN || state == ST_END))
    else $error("pending expiry held outside a tick scan");

  a_scan_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && remain_we) |-> (rd_addr != idx))
    else $error("countdown write and read hit the same slot during a scan");
`endif

endmodule
